// ===== rtl/lps_pkg.sv =====
// Shared types and codes for the link primary station block.
package lps_pkg;

    // Received event codes; these match the action field encoding
    typedef enum logic [3:0] {
        EV_SEND_UNCONF = 4'd0,
        EV_SEND_CONF   = 4'd1,
        EV_TX_DONE     = 4'd2,
        EV_ACK         = 4'd3,
        EV_NACK        = 4'd4,
        EV_LINK_STATUS = 4'd5,
        EV_NOT_SUPP    = 4'd6,
        EV_TIMEOUT     = 4'd7,
        EV_FAILURE     = 4'd8,
        EV_INVALID     = 4'd9
    } ev_t;

    // Link states
    typedef enum logic [2:0] {
        ST_NOT_RESET     = 3'd0,
        ST_RESET         = 3'd1,
        ST_RST_TXWAIT    = 3'd2,
        ST_DATA_TXWAIT   = 3'd3,
        ST_RST_ACKWAIT   = 3'd4,
        ST_DATA_ACKWAIT  = 3'd5,
        ST_UNCONF_TXWAIT = 3'd6
    } link_state_t;

    // Frame to queue
    typedef enum logic [1:0] {
        FR_NONE   = 2'd0,
        FR_RESET  = 2'd1,
        FR_CONF   = 2'd2,
        FR_UNCONF = 2'd3
    } frame_t;

    // Response timer commands
    typedef enum logic [1:0] {
        TM_NONE   = 2'd0,
        TM_START  = 2'd1,
        TM_CANCEL = 2'd2
    } timer_t;

    // Input request as seen on the ports
    typedef struct packed {
        logic [3:0] action;
        logic       tx_success;
        logic       receive_buffer_full;
        logic       more_segments;
    } in_item_t;

    // Result as seen on the ports
    typedef struct packed {
        logic [1:0] frame_request;
        logic       frame_fcb;
        logic [1:0] timer_command;
        logic       result_valid;
        logic       result_ok;
        logic       unexpected_event;
        logic [2:0] link_state_out;
        logic [7:0] retries_left_out;
    } out_item_t;

    // Classified command passed from front to back
    typedef struct packed {
        ev_t  ev;
        logic txok;
        logic dfc;
        logic more;
    } cmd_t;

    // Head of the command queue as offered to the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

// ===== rtl/lps_front.sv =====
// Front end: accepts requests, classifies the action and queues commands.
module lps_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lps_pkg::in_item_t  item,
    output lps_pkg::cmd_head_t head,
    input  logic               take
);

    lps_pkg::cmd_t cmd_mem [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    lps_pkg::cmd_t cls;
    logic          do_push, do_pop;

    // Classify: out-of-range action codes become invalid events
    always_comb
    begin
        if (item.action <= lps_pkg::EV_FAILURE)
            cls.ev = lps_pkg::ev_t'(item.action);
        else
            cls.ev = lps_pkg::EV_INVALID;
        cls.txok = item.tx_success;
        cls.dfc  = item.receive_buffer_full;
        cls.more = item.more_segments;
    end

    assign full     = (count_reg == 2'd2);
    assign do_push  = push && !full;
    assign do_pop   = take && (count_reg != 2'd0);
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = cmd_mem[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            cmd_mem[wr_ptr_reg] <= cls;
    end

endmodule

// ===== rtl/lps_back.sv =====
// Back end: link state machine and result queue.
module lps_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  lps_pkg::cmd_head_t head,
    output logic               take,
    output logic               empty,
    input  logic               pop,
    output lps_pkg::out_item_t result_item
);

    lps_pkg::link_state_t state_reg, state_next;
    logic                 fcb_reg, fcb_next;
    logic                 unc_reg, unc_next;
    logic [7:0]           retries_reg, retries_next;
    logic [7:0]           limit_reg;

    lps_pkg::out_item_t   res_mem [2];
    logic                 wr_ptr_reg, rd_ptr_reg;
    logic [1:0]           count_reg, count_next;
    logic                 do_pop;

    lps_pkg::cmd_t        c;
    lps_pkg::frame_t      frame;
    lps_pkg::timer_t      timer;
    logic                 fcb_o, valid_o, ok_o, unexp_o;
    lps_pkg::out_item_t   res;

    assign c         = head.cmd;
    assign cfg_ready = 1'b1;
    assign do_pop    = pop && (count_reg != 2'd0);
    assign empty     = (count_reg == 2'd0);
    assign take      = head.valid && ((count_reg != 2'd2) || do_pop);
    assign result_item = res_mem[rd_ptr_reg];

    // Retry limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 8'd0;
        else if (cfg_valid && cfg_ready)
            limit_reg <= cfg_data;
    end

    // Next state and stored link variables
    always_comb
    begin
        state_next   = state_reg;
        fcb_next     = fcb_reg;
        unc_next     = unc_reg;
        retries_next = retries_reg;
        case (state_reg)
            lps_pkg::ST_NOT_RESET, lps_pkg::ST_RESET:
            begin
                if (c.ev == lps_pkg::EV_SEND_UNCONF)
                begin
                    unc_next   = (state_reg == lps_pkg::ST_RESET);
                    state_next = lps_pkg::ST_UNCONF_TXWAIT;
                end
                else if (c.ev == lps_pkg::EV_SEND_CONF)
                begin
                    retries_next = limit_reg;
                    state_next   = (state_reg == lps_pkg::ST_RESET) ?
                                   lps_pkg::ST_DATA_TXWAIT : lps_pkg::ST_RST_TXWAIT;
                end
            end
            lps_pkg::ST_RST_TXWAIT:
            begin
                if (c.ev == lps_pkg::EV_TX_DONE)
                    state_next = c.txok ? lps_pkg::ST_RST_ACKWAIT : lps_pkg::ST_NOT_RESET;
            end
            lps_pkg::ST_DATA_TXWAIT:
            begin
                if (c.ev == lps_pkg::EV_TX_DONE)
                    state_next = c.txok ? lps_pkg::ST_DATA_ACKWAIT : lps_pkg::ST_RESET;
            end
            lps_pkg::ST_RST_ACKWAIT:
            begin
                if (c.ev == lps_pkg::EV_ACK)
                begin
                    fcb_next   = 1'b1;
                    state_next = lps_pkg::ST_DATA_TXWAIT;
                end
                else if (c.ev == lps_pkg::EV_TIMEOUT)
                begin
                    if (retries_reg != 8'd0)
                    begin
                        retries_next = retries_reg - 8'd1;
                        state_next   = lps_pkg::ST_RST_TXWAIT;
                    end
                    else
                        state_next = lps_pkg::ST_NOT_RESET;
                end
                else if (c.ev == lps_pkg::EV_FAILURE)
                    state_next = lps_pkg::ST_NOT_RESET;
            end
            lps_pkg::ST_DATA_ACKWAIT:
            begin
                if (c.ev == lps_pkg::EV_ACK)
                begin
                    fcb_next   = ~fcb_reg;
                    state_next = c.more ? lps_pkg::ST_DATA_TXWAIT : lps_pkg::ST_RESET;
                end
                else if (c.ev == lps_pkg::EV_FAILURE || (c.ev == lps_pkg::EV_NACK && c.dfc))
                    state_next = lps_pkg::ST_NOT_RESET;
                else if (c.ev == lps_pkg::EV_NACK)
                begin
                    retries_next = limit_reg;
                    state_next   = lps_pkg::ST_RST_TXWAIT;
                end
                else if (c.ev == lps_pkg::EV_TIMEOUT)
                begin
                    if (retries_reg != 8'd0)
                    begin
                        retries_next = retries_reg - 8'd1;
                        state_next   = lps_pkg::ST_DATA_TXWAIT;
                    end
                    else
                        state_next = lps_pkg::ST_NOT_RESET;
                end
            end
            lps_pkg::ST_UNCONF_TXWAIT:
            begin
                if (c.ev == lps_pkg::EV_TX_DONE && !c.more)
                    state_next = unc_reg ? lps_pkg::ST_RESET : lps_pkg::ST_NOT_RESET;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // Result fields for the current event
    always_comb
    begin
        frame   = lps_pkg::FR_NONE;
        timer   = lps_pkg::TM_NONE;
        fcb_o   = 1'b0;
        valid_o = 1'b0;
        ok_o    = 1'b0;
        unexp_o = 1'b0;
        case (state_reg)
            lps_pkg::ST_NOT_RESET, lps_pkg::ST_RESET:
            begin
                if (c.ev == lps_pkg::EV_SEND_UNCONF)
                    frame = lps_pkg::FR_UNCONF;
                else if (c.ev == lps_pkg::EV_SEND_CONF)
                begin
                    if (state_reg == lps_pkg::ST_RESET)
                    begin
                        frame = lps_pkg::FR_CONF;
                        fcb_o = fcb_reg;
                    end
                    else
                        frame = lps_pkg::FR_RESET;
                end
                else
                    unexp_o = 1'b1;
            end
            lps_pkg::ST_RST_TXWAIT, lps_pkg::ST_DATA_TXWAIT:
            begin
                if (c.ev == lps_pkg::EV_TX_DONE)
                begin
                    if (c.txok)
                        timer = lps_pkg::TM_START;
                    else
                        valid_o = 1'b1;
                end
                else
                    unexp_o = 1'b1;
            end
            lps_pkg::ST_RST_ACKWAIT:
            begin
                if (c.ev == lps_pkg::EV_ACK)
                begin
                    timer = lps_pkg::TM_CANCEL;
                    frame = lps_pkg::FR_CONF;
                    fcb_o = 1'b1;
                end
                else if (c.ev == lps_pkg::EV_TIMEOUT)
                begin
                    if (retries_reg != 8'd0)
                        frame = lps_pkg::FR_RESET;
                    else
                        valid_o = 1'b1;
                end
                else if (c.ev == lps_pkg::EV_FAILURE)
                begin
                    timer   = lps_pkg::TM_CANCEL;
                    valid_o = 1'b1;
                end
                else
                    unexp_o = 1'b1;
            end
            lps_pkg::ST_DATA_ACKWAIT:
            begin
                if (c.ev == lps_pkg::EV_ACK)
                begin
                    timer = lps_pkg::TM_CANCEL;
                    if (c.more)
                    begin
                        frame = lps_pkg::FR_CONF;
                        fcb_o = ~fcb_reg;
                    end
                    else
                    begin
                        valid_o = 1'b1;
                        ok_o    = 1'b1;
                    end
                end
                else if (c.ev == lps_pkg::EV_FAILURE || (c.ev == lps_pkg::EV_NACK && c.dfc))
                begin
                    timer   = lps_pkg::TM_CANCEL;
                    valid_o = 1'b1;
                end
                else if (c.ev == lps_pkg::EV_NACK)
                begin
                    timer = lps_pkg::TM_CANCEL;
                    frame = lps_pkg::FR_RESET;
                end
                else if (c.ev == lps_pkg::EV_TIMEOUT)
                begin
                    if (retries_reg != 8'd0)
                    begin
                        frame = lps_pkg::FR_CONF;
                        fcb_o = fcb_reg;
                    end
                    else
                        valid_o = 1'b1;
                end
                else
                    unexp_o = 1'b1;
            end
            lps_pkg::ST_UNCONF_TXWAIT:
            begin
                if (c.ev == lps_pkg::EV_TX_DONE)
                begin
                    if (c.more)
                        frame = lps_pkg::FR_UNCONF;
                    else
                    begin
                        valid_o = 1'b1;
                        ok_o    = c.txok;
                    end
                end
                else
                    unexp_o = 1'b1;
            end
            default:
            begin
                unexp_o = 1'b1;
            end
        endcase

        res.frame_request    = frame;
        res.frame_fcb        = fcb_o;
        res.timer_command    = timer;
        res.result_valid     = valid_o;
        res.result_ok        = ok_o;
        res.unexpected_event = unexp_o;
        res.link_state_out   = state_next;
        res.retries_left_out = retries_next;
    end

    // Link state registers, advanced once per executed command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= lps_pkg::ST_NOT_RESET;
            fcb_reg     <= 1'b0;
            unc_reg     <= 1'b0;
            retries_reg <= 8'd0;
        end
        else if (take)
        begin
            state_reg   <= state_next;
            fcb_reg     <= fcb_next;
            unc_reg     <= unc_next;
            retries_reg <= retries_next;
        end
    end

    // Result queue control
    assign count_next = count_reg + {1'b0, take} - {1'b0, do_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (take)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Result storage
    always_ff @(posedge clk)
    begin
        if (take)
            res_mem[wr_ptr_reg] <= res;
    end

endmodule

// ===== rtl/link_primary_station_fsm_unit.sv =====
// Top level of the link primary station: front end, command queue and state machine.
//
//  Channel     Handshake          Payload
//  ----------  -----------------  --------------------------------------
//  events      push / full        event_item  (lps_pkg::in_item_t)
//  results     pop / empty        result_item (lps_pkg::out_item_t)
//  config      cfg_valid/ready    cfg_data    (retry limit, 8 bits)
//
// One request per cycle is sustained while results are popped; a request is stored in the
// command queue when accepted, then executed by one state step that writes its result
// to the result queue, which drives the result ports.
// Both queues hold two entries, so either side may stall without blocking the
// other until its queue fills. Reset clears the link state, counters and
// queues; the retry limit resets to zero. cfg_ready is always high.
module link_primary_station_fsm_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  lps_pkg::in_item_t  event_item,
    output logic               empty,
    input  logic               pop,
    output lps_pkg::out_item_t result_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);

    lps_pkg::cmd_head_t head;
    logic               take;

    // Request acceptance and classification
    lps_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (event_item),
        .head  (head),
        .take  (take)
    );

    // State machine and result queue
    lps_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .head        (head),
        .take        (take),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item)
    );

endmodule
